// ===== rtl/brent_root_finder_macros.svh =====
// Assertion macros shared by the brent_root_finder RTL.
// Depends on nothing; included by files that carry concurrent assertions.
`ifndef BRENT_ROOT_FINDER_MACROS_SVH
`define BRENT_ROOT_FINDER_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define BRF_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset.
`define BRF_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/brf_pkg.sv =====
// Package for the Brent root finder: formats, codes, types and saturating helpers.
// Depends on nothing; used by the interfaces, the arithmetic unit and the top level.
package brf_pkg;

   localparam int POINT_WIDTH    = 32;
   localparam int VALUE_WIDTH    = 32;
   localparam int WIDE_WIDTH     = 64;
   localparam int RATIO_FRAC     = 30;
   localparam int EPS2_SHIFT     = 48;
   localparam int RATIO_BITS     = 62;
   localparam int CSR_ADDR_WIDTH = 3;

   typedef logic signed [WIDE_WIDTH-1:0]  wide_type;
   typedef logic signed [POINT_WIDTH-1:0] point_type;
   typedef logic signed [VALUE_WIDTH-1:0] value_type;

   localparam wide_type  SAT_LIM   = 64'sh3FFF_FFFF_FFFF_FFFF;
   localparam wide_type  ONE_Q30   = 64'sh0000_0000_4000_0000;
   localparam wide_type  EPS2_Q48  = 64'sd16888499;
   localparam wide_type  PMAX_W    = (64'sd1 <<< (POINT_WIDTH - 1)) - 64'sd1;
   localparam wide_type  PMIN_W    = -PMAX_W - 64'sd1;
   localparam point_type POINT_ONE = point_type'(64'sd1 <<< (POINT_WIDTH - 2));

   localparam logic [30:0] TOL_RESET   = 31'd10737;
   localparam logic [9:0]  MAXIT_RESET = 10'd100;

   // Word index of each control register.
   localparam logic REG_TOLERANCE = 1'b0;
   localparam logic REG_MAX_ITER  = 1'b1;

   typedef enum logic [1:0] {
      STATUS_BUSY, STATUS_CONVERGED, STATUS_UNBRACKETED, STATUS_LIMIT
   } status_type;

   typedef enum logic [1:0] {PH_IDLE, PH_FIRST, PH_REFINE} phase_type;

   typedef enum logic [1:0] {OP_MUL30, OP_MUL48, OP_DIV} arith_op_type;

   typedef enum logic [1:0] {AU_IDLE, AU_MUL, AU_DIV, AU_FIN} arith_state_type;

   typedef enum logic [4:0] {
      ST_IDLE, ST_R0, ST_R1, ST_TOL, ST_CHK, ST_S, ST_P1, ST_QQ, ST_RR,
      ST_T1A, ST_T1B, ST_T2, ST_P3, ST_Q3A, ST_Q3B, ST_SGN, ST_M1A, ST_M1B,
      ST_M2, ST_CMP, ST_DIVD, ST_STEP, ST_DONE
   } state_type;

   typedef struct packed {
      logic         start;
      arith_op_type op;
      wide_type     x;
      wide_type     y;
   } arith_req_type;

   typedef struct packed {
      logic     done;
      wide_type result;
   } arith_rsp_type;

   function automatic logic [WIDE_WIDTH-1:0] mag_w(input wide_type x);
      return x[WIDE_WIDTH-1] ? WIDE_WIDTH'(-x) : WIDE_WIDTH'(x);
   endfunction

   function automatic wide_type widen_p(input point_type p);
      return wide_type'(p);
   endfunction

   function automatic wide_type widen_v(input value_type v);
      return wide_type'(v);
   endfunction

   function automatic wide_type sat_add(input wide_type x, input wide_type y);
      logic signed [WIDE_WIDTH:0] sx;
      logic signed [WIDE_WIDTH:0] sy;
      logic signed [WIDE_WIDTH:0] sum;
      logic signed [WIDE_WIDTH:0] lim;
      sx  = x;
      sy  = y;
      lim = SAT_LIM;
      sum = sx + sy;
      if (sum > lim) return SAT_LIM;
      if (sum < -lim) return -SAT_LIM;
      return wide_type'(sum);
   endfunction

   function automatic wide_type sat_sub(input wide_type x, input wide_type y);
      return sat_add(x, -y);
   endfunction

   function automatic point_type pclamp(input wide_type x);
      if (x > PMAX_W) return point_type'(PMAX_W);
      if (x < PMIN_W) return point_type'(PMIN_W);
      return point_type'(x);
   endfunction

   // Halve, truncating toward zero.
   function automatic wide_type half_tz(input wide_type x);
      return x[WIDE_WIDTH-1] ? ((x + 64'sd1) >>> 1) : (x >>> 1);
   endfunction

   function automatic logic same_sign(input value_type x, input value_type y);
      return (x > 0 && y > 0) || (x < 0 && y < 0);
   endfunction

endpackage

// ===== rtl/brf_req_if.sv =====
// Input channel of the Brent root finder: mode and function value.
// Depends on brf_pkg for the value width.
interface brf_req_if;
   logic                  valid;
   logic                  ready;
   logic                  mode;
   brf_pkg::value_type    fvalue;

   modport source (output valid, output mode, output fvalue, input ready);
   modport sink   (input valid, input mode, input fvalue, output ready);
endinterface

// ===== rtl/brf_rsp_if.sv =====
// Result channel of the Brent root finder: point, final flag and status.
// Depends on brf_pkg for the point width.
interface brf_rsp_if;
   logic                  valid;
   logic                  ready;
   brf_pkg::point_type    point;
   logic                  done_res;
   logic [1:0]            status;

   modport source (output valid, output point, output done_res, output status, input ready);
   modport sink   (input valid, input point, input done_res, input status, output ready);
endinterface

// ===== rtl/brent_root_finder.sv =====
// Brent root finder on [0,1]: one result item per input item; not ready while working.
// A new start, an unbracketed pair, a value while idle or a zero limit goes to ST_DONE after
// acceptance; a bisection step runs the tolerance multiply on the shared unit, and an
// interpolated step adds multiplies and divisions (one quotient bit a cycle, up to four
// divisions a step). A new item is taken once the last result is in the output register.
// Synchronous reset returns to idle with default tolerance and limit.
`include "brent_root_finder_macros.svh"

module brent_root_finder (
   input  logic                                  clock,
   input  logic                                  reset,
   brf_req_if.sink                               req_ch,
   brf_rsp_if.source                             rsp_ch,
   input  logic                                  csr_psel,
   input  logic                                  csr_penable,
   input  logic                                  csr_pwrite,
   input  logic [brf_pkg::CSR_ADDR_WIDTH-1:0]    csr_paddr,
   input  logic [31:0]                           csr_pwdata,
   output logic [31:0]                           csr_prdata,
   output logic                                  csr_pready
);

   brf_pkg::state_type  state_ff, state_in;
   logic                wait_ff, wait_in;
   brf_pkg::phase_type  phase_ff, phase_in;
   brf_pkg::point_type  ap_ff, ap_in, bp_ff, bp_in, cp_ff, cp_in;
   brf_pkg::value_type  av_ff, av_in, bv_ff, bv_in, cv_ff, cv_in;
   brf_pkg::point_type  d_ff, d_in, e_ff, e_in;
   logic [9:0]          iter_ff, iter_in;
   logic [30:0]         tol_ff;
   logic [9:0]          maxit_ff;
   brf_pkg::wide_type   tol1_ff, tol1_in, xm_ff, xm_in, s_ff, s_in, qq_ff, qq_in;
   brf_pkg::wide_type   r_ff, r_in, tmp_ff, tmp_in, t1_ff, t1_in, p_ff, p_in;
   brf_pkg::wide_type   q_ff, q_in, m1_ff, m1_in, m2_ff, m2_in;
   brf_pkg::point_type  res_point_ff, res_point_in;
   brf_pkg::status_type res_status_ff, res_status_in;
   logic                rsp_valid_ff, rsp_valid_in;
   brf_pkg::point_type  rsp_point_ff, rsp_point_in;
   brf_pkg::status_type rsp_status_ff, rsp_status_in;

   brf_pkg::arith_req_type arith_req;
   brf_pkg::arith_rsp_type arith_rsp;

   logic                accept;
   logic                csr_write;
   logic                use_unit;
   logic                got;
   brf_pkg::wide_type   res;
   brf_pkg::wide_type   aw, bw, cw;
   brf_pkg::wide_type   lim;
   brf_pkg::point_type  step_d;
   brf_pkg::point_type  nb;
   logic [9:0]          iter_inc;

   brf_arith_unit u_arith (
      .clock (clock),
      .reset (reset),
      .req_i (arith_req),
      .rsp_o (arith_rsp)
   );

   assign accept    = req_ch.valid && req_ch.ready;
   assign csr_write = csr_psel && csr_penable && csr_pwrite && csr_pready;

   // Control registers and their read-back.
   assign csr_pready = 1'b1;
   always_comb begin
      case (csr_paddr[2])
         brf_pkg::REG_TOLERANCE: csr_prdata = {1'b0, tol_ff};
         brf_pkg::REG_MAX_ITER:  csr_prdata = {22'd0, maxit_ff};
         default:                csr_prdata = 32'd0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tol_ff   <= brf_pkg::TOL_RESET;
         maxit_ff <= brf_pkg::MAXIT_RESET;
      end else if (csr_write) begin
         case (csr_paddr[2])
            brf_pkg::REG_TOLERANCE: tol_ff   <= csr_pwdata[30:0];
            brf_pkg::REG_MAX_ITER:  maxit_ff <= csr_pwdata[9:0];
            default: begin
            end
         endcase
      end
   end

   // Sequencer state and search registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= brf_pkg::ST_IDLE;
         wait_ff      <= 1'b0;
         phase_ff     <= brf_pkg::PH_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         wait_ff      <= wait_in;
         phase_ff     <= phase_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      ap_ff         <= ap_in;
      bp_ff         <= bp_in;
      cp_ff         <= cp_in;
      av_ff         <= av_in;
      bv_ff         <= bv_in;
      cv_ff         <= cv_in;
      d_ff          <= d_in;
      e_ff          <= e_in;
      iter_ff       <= iter_in;
      tol1_ff       <= tol1_in;
      xm_ff         <= xm_in;
      s_ff          <= s_in;
      qq_ff         <= qq_in;
      r_ff          <= r_in;
      tmp_ff        <= tmp_in;
      t1_ff         <= t1_in;
      p_ff          <= p_in;
      q_ff          <= q_in;
      m1_ff         <= m1_in;
      m2_ff         <= m2_in;
      res_point_ff  <= res_point_in;
      res_status_ff <= res_status_in;
      rsp_point_ff  <= rsp_point_in;
      rsp_status_ff <= rsp_status_in;
   end

   // Next state: one Brent iteration as a sequence of unit operations.
   always_comb begin
      state_in      = state_ff;
      wait_in       = wait_ff;
      phase_in      = phase_ff;
      ap_in         = ap_ff;
      bp_in         = bp_ff;
      cp_in         = cp_ff;
      av_in         = av_ff;
      bv_in         = bv_ff;
      cv_in         = cv_ff;
      d_in          = d_ff;
      e_in          = e_ff;
      iter_in       = iter_ff;
      tol1_in       = tol1_ff;
      xm_in         = xm_ff;
      s_in          = s_ff;
      qq_in         = qq_ff;
      r_in          = r_ff;
      tmp_in        = tmp_ff;
      t1_in         = t1_ff;
      p_in          = p_ff;
      q_in          = q_ff;
      m1_in         = m1_ff;
      m2_in         = m2_ff;
      res_point_in  = res_point_ff;
      res_status_in = res_status_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ch.ready;
      rsp_point_in  = rsp_point_ff;
      rsp_status_in = rsp_status_ff;

      use_unit      = 1'b0;
      arith_req.op  = brf_pkg::OP_MUL30;
      arith_req.x   = brf_pkg::wide_type'(0);
      arith_req.y   = brf_pkg::wide_type'(0);
      got           = wait_ff && arith_rsp.done;
      res           = arith_rsp.result;
      aw            = brf_pkg::widen_p(ap_ff);
      bw            = brf_pkg::widen_p(bp_ff);
      cw            = brf_pkg::widen_p(cp_ff);
      lim           = (m1_ff < m2_ff) ? m1_ff : m2_ff;
      step_d        = brf_pkg::pclamp(bw - aw);
      iter_inc      = iter_ff + 10'd1;
      if (brf_pkg::mag_w(brf_pkg::widen_p(d_ff)) > brf_pkg::mag_w(tol1_ff)) begin
         nb = brf_pkg::pclamp(brf_pkg::sat_add(bw, brf_pkg::widen_p(d_ff)));
      end else if (xm_ff < 0) begin
         nb = brf_pkg::pclamp(brf_pkg::sat_sub(bw, tol1_ff));
      end else begin
         nb = brf_pkg::pclamp(brf_pkg::sat_add(bw, tol1_ff));
      end

      case (state_ff)
         brf_pkg::ST_IDLE: begin
            if (accept) begin
               if (req_ch.mode == 1'b0) begin
                  // New search: remember f(0) and ask for f(1).
                  ap_in         = '0;
                  av_in         = req_ch.fvalue;
                  bp_in         = brf_pkg::POINT_ONE;
                  iter_in       = 10'd0;
                  phase_in      = brf_pkg::PH_FIRST;
                  res_point_in  = brf_pkg::POINT_ONE;
                  res_status_in = brf_pkg::STATUS_BUSY;
                  state_in      = brf_pkg::ST_DONE;
               end else begin
                  case (phase_ff)
                     brf_pkg::PH_FIRST: begin
                        bv_in = req_ch.fvalue;
                        if (brf_pkg::same_sign(av_ff, req_ch.fvalue)) begin
                           phase_in      = brf_pkg::PH_IDLE;
                           res_point_in  = '0;
                           res_status_in = brf_pkg::STATUS_UNBRACKETED;
                           state_in      = brf_pkg::ST_DONE;
                        end else begin
                           cp_in   = '0;
                           cv_in   = req_ch.fvalue;
                           d_in    = '0;
                           e_in    = '0;
                           iter_in = 10'd0;
                           if (maxit_ff == 10'd0) begin
                              phase_in      = brf_pkg::PH_IDLE;
                              res_point_in  = bp_ff;
                              res_status_in = brf_pkg::STATUS_LIMIT;
                              state_in      = brf_pkg::ST_DONE;
                           end else begin
                              state_in = brf_pkg::ST_R0;
                           end
                        end
                     end
                     brf_pkg::PH_REFINE: begin
                        bv_in    = req_ch.fvalue;
                        state_in = brf_pkg::ST_R0;
                     end
                     default: begin
                        // A value with no search running changes nothing.
                        res_point_in  = '0;
                        res_status_in = brf_pkg::STATUS_UNBRACKETED;
                        state_in      = brf_pkg::ST_DONE;
                     end
                  endcase
               end
            end
         end
         brf_pkg::ST_R0: begin
            // Keep the root bracketed between b and c.
            if (brf_pkg::same_sign(bv_ff, cv_ff)) begin
               cp_in = ap_ff;
               cv_in = av_ff;
               d_in  = step_d;
               e_in  = step_d;
            end
            state_in = brf_pkg::ST_R1;
         end
         brf_pkg::ST_R1: begin
            // Make b the better of the two bracket ends.
            if (brf_pkg::mag_w(brf_pkg::widen_v(cv_ff)) <
                brf_pkg::mag_w(brf_pkg::widen_v(bv_ff))) begin
               ap_in = bp_ff;
               bp_in = cp_ff;
               cp_in = bp_ff;
               av_in = bv_ff;
               bv_in = cv_ff;
               cv_in = bv_ff;
            end
            state_in = brf_pkg::ST_TOL;
         end
         brf_pkg::ST_TOL: begin
            use_unit     = 1'b1;
            arith_req.op = brf_pkg::OP_MUL48;
            arith_req.x  = brf_pkg::wide_type'(brf_pkg::mag_w(bw));
            arith_req.y  = brf_pkg::EPS2_Q48;
            if (got) begin
               tol1_in  = brf_pkg::sat_add(res, brf_pkg::wide_type'({34'd0, tol_ff[30:1]}));
               xm_in    = brf_pkg::half_tz(brf_pkg::sat_sub(cw, bw));
               state_in = brf_pkg::ST_CHK;
            end
         end
         brf_pkg::ST_CHK: begin
            if (brf_pkg::mag_w(xm_ff) <= brf_pkg::mag_w(tol1_ff) || bv_ff == '0) begin
               phase_in      = brf_pkg::PH_IDLE;
               res_point_in  = bp_ff;
               res_status_in = brf_pkg::STATUS_CONVERGED;
               state_in      = brf_pkg::ST_DONE;
            end else if (brf_pkg::mag_w(brf_pkg::widen_p(e_ff)) >= brf_pkg::mag_w(tol1_ff) &&
                         brf_pkg::mag_w(brf_pkg::widen_v(av_ff)) >
                         brf_pkg::mag_w(brf_pkg::widen_v(bv_ff))) begin
               state_in = brf_pkg::ST_S;
            end else begin
               d_in     = brf_pkg::pclamp(xm_ff);
               e_in     = brf_pkg::pclamp(xm_ff);
               state_in = brf_pkg::ST_STEP;
            end
         end
         brf_pkg::ST_S: begin
            use_unit     = 1'b1;
            arith_req.op = brf_pkg::OP_DIV;
            arith_req.x  = brf_pkg::widen_v(bv_ff);
            arith_req.y  = brf_pkg::widen_v(av_ff);
            if (got) begin
               s_in     = res;
               state_in = (ap_ff == cp_ff) ? brf_pkg::ST_P1 : brf_pkg::ST_QQ;
            end
         end
         brf_pkg::ST_P1: begin
            // Secant step.
            use_unit    = 1'b1;
            arith_req.x = brf_pkg::sat_add(xm_ff, xm_ff);
            arith_req.y = s_ff;
            if (got) begin
               p_in     = res;
               q_in     = brf_pkg::sat_sub(brf_pkg::ONE_Q30, s_ff);
               state_in = brf_pkg::ST_SGN;
            end
         end
         brf_pkg::ST_QQ: begin
            // Inverse quadratic step from here to ST_Q3B.
            use_unit     = 1'b1;
            arith_req.op = brf_pkg::OP_DIV;
            arith_req.x  = brf_pkg::widen_v(av_ff);
            arith_req.y  = brf_pkg::widen_v(cv_ff);
            if (got) begin
               qq_in    = res;
               state_in = brf_pkg::ST_RR;
            end
         end
         brf_pkg::ST_RR: begin
            use_unit     = 1'b1;
            arith_req.op = brf_pkg::OP_DIV;
            arith_req.x  = brf_pkg::widen_v(bv_ff);
            arith_req.y  = brf_pkg::widen_v(cv_ff);
            if (got) begin
               r_in     = res;
               state_in = brf_pkg::ST_T1A;
            end
         end
         brf_pkg::ST_T1A: begin
            use_unit    = 1'b1;
            arith_req.x = brf_pkg::sat_add(xm_ff, xm_ff);
            arith_req.y = qq_ff;
            if (got) begin
               tmp_in   = res;
               state_in = brf_pkg::ST_T1B;
            end
         end
         brf_pkg::ST_T1B: begin
            use_unit    = 1'b1;
            arith_req.x = tmp_ff;
            arith_req.y = brf_pkg::sat_sub(qq_ff, r_ff);
            if (got) begin
               t1_in    = res;
               state_in = brf_pkg::ST_T2;
            end
         end
         brf_pkg::ST_T2: begin
            use_unit    = 1'b1;
            arith_req.x = brf_pkg::sat_sub(bw, aw);
            arith_req.y = brf_pkg::sat_sub(r_ff, brf_pkg::ONE_Q30);
            if (got) begin
               tmp_in   = res;
               state_in = brf_pkg::ST_P3;
            end
         end
         brf_pkg::ST_P3: begin
            use_unit    = 1'b1;
            arith_req.x = s_ff;
            arith_req.y = brf_pkg::sat_sub(t1_ff, tmp_ff);
            if (got) begin
               p_in     = res;
               state_in = brf_pkg::ST_Q3A;
            end
         end
         brf_pkg::ST_Q3A: begin
            use_unit    = 1'b1;
            arith_req.x = brf_pkg::sat_sub(qq_ff, brf_pkg::ONE_Q30);
            arith_req.y = brf_pkg::sat_sub(r_ff, brf_pkg::ONE_Q30);
            if (got) begin
               tmp_in   = res;
               state_in = brf_pkg::ST_Q3B;
            end
         end
         brf_pkg::ST_Q3B: begin
            use_unit    = 1'b1;
            arith_req.x = tmp_ff;
            arith_req.y = brf_pkg::sat_sub(s_ff, brf_pkg::ONE_Q30);
            if (got) begin
               q_in     = res;
               state_in = brf_pkg::ST_SGN;
            end
         end
         brf_pkg::ST_SGN: begin
            if (p_ff > 0) begin
               q_in = -q_ff;
            end
            p_in     = brf_pkg::wide_type'(brf_pkg::mag_w(p_ff));
            state_in = brf_pkg::ST_M1A;
         end
         brf_pkg::ST_M1A: begin
            // Bounds that decide whether the interpolated step is accepted.
            use_unit    = 1'b1;
            arith_req.x = brf_pkg::sat_add(brf_pkg::sat_add(xm_ff, xm_ff), xm_ff);
            arith_req.y = q_ff;
            if (got) begin
               m1_in    = res;
               state_in = brf_pkg::ST_M1B;
            end
         end
         brf_pkg::ST_M1B: begin
            use_unit    = 1'b1;
            arith_req.x = tol1_ff;
            arith_req.y = q_ff;
            if (got) begin
               m1_in    = brf_pkg::sat_sub(m1_ff, brf_pkg::wide_type'(brf_pkg::mag_w(res)));
               state_in = brf_pkg::ST_M2;
            end
         end
         brf_pkg::ST_M2: begin
            use_unit    = 1'b1;
            arith_req.x = brf_pkg::widen_p(e_ff);
            arith_req.y = q_ff;
            if (got) begin
               m2_in    = brf_pkg::wide_type'(brf_pkg::mag_w(res));
               state_in = brf_pkg::ST_CMP;
            end
         end
         brf_pkg::ST_CMP: begin
            if (brf_pkg::sat_add(p_ff, p_ff) < lim) begin
               e_in     = d_ff;
               state_in = brf_pkg::ST_DIVD;
            end else begin
               d_in     = brf_pkg::pclamp(xm_ff);
               e_in     = brf_pkg::pclamp(xm_ff);
               state_in = brf_pkg::ST_STEP;
            end
         end
         brf_pkg::ST_DIVD: begin
            use_unit     = 1'b1;
            arith_req.op = brf_pkg::OP_DIV;
            arith_req.x  = p_ff;
            arith_req.y  = q_ff;
            if (got) begin
               d_in     = brf_pkg::pclamp(res);
               state_in = brf_pkg::ST_STEP;
            end
         end
         brf_pkg::ST_STEP: begin
            // Move to the new best point and count the iteration.
            ap_in        = bp_ff;
            av_in        = bv_ff;
            bp_in        = nb;
            iter_in      = iter_inc;
            res_point_in = nb;
            if (iter_inc >= maxit_ff) begin
               phase_in      = brf_pkg::PH_IDLE;
               res_status_in = brf_pkg::STATUS_LIMIT;
            end else begin
               phase_in      = brf_pkg::PH_REFINE;
               res_status_in = brf_pkg::STATUS_BUSY;
            end
            state_in = brf_pkg::ST_DONE;
         end
         brf_pkg::ST_DONE: begin
            // Hand the result item to the output register once it is free.
            if (!rsp_valid_ff || rsp_ch.ready) begin
               rsp_valid_in  = 1'b1;
               rsp_point_in  = res_point_ff;
               rsp_status_in = res_status_ff;
               state_in      = brf_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = brf_pkg::ST_IDLE;
         end
      endcase

      arith_req.start = use_unit && !wait_ff;
      if (use_unit) begin
         wait_in = !got;
      end
   end

   assign req_ch.ready    = (state_ff == brf_pkg::ST_IDLE);
   assign rsp_ch.valid    = rsp_valid_ff;
   assign rsp_ch.point    = rsp_point_ff;
   assign rsp_ch.status   = rsp_status_ff;
   assign rsp_ch.done_res = (rsp_status_ff != brf_pkg::STATUS_BUSY);

   // The unit never answers in the cycle after it was started.
   `BRF_ASSERT_NEXT(a_unit_latency, clock, reset, arith_req.start, !arith_rsp.done, "unit answered too early")
   // A unit result only arrives while the sequencer waits for it.
   `BRF_ASSERT_NOW(a_unit_expected, clock, reset, arith_rsp.done, wait_ff, "unexpected unit result")
   // Every accepted item leaves the idle state.
   `BRF_ASSERT_NEXT(a_item_taken, clock, reset, accept, state_ff != brf_pkg::ST_IDLE, "item dropped")

endmodule

// ===== rtl/brf_arith_unit.sv =====
// Shared multi-cycle multiply and divide unit of the Brent root finder.
// Depends on brf_pkg for operand types, saturation limit and op codes.
module brf_arith_unit (
   input  logic                   clock,
   input  logic                   reset,
   input  brf_pkg::arith_req_type req_i,
   output brf_pkg::arith_rsp_type rsp_o
);

   brf_pkg::arith_state_type au_state_ff, au_state_in;
   brf_pkg::arith_op_type    op_ff, op_in;
   logic                     neg_ff, neg_in;
   logic                     sat_ff, sat_in;
   logic [61:0]              a_ff, a_in;
   logic [61:0]              b_ff, b_in;
   logic [123:0]             acc_ff, acc_in;
   logic [5:0]               step_ff, step_in;
   logic [61:0]              rem_ff, rem_in;
   logic [61:0]              num_ff, num_in;
   logic [61:0]              quo_ff, quo_in;
   brf_pkg::wide_type        result_ff, result_in;
   logic                     done_ff, done_in;

   logic [63:0]  x_mag;
   logic [63:0]  y_mag;
   logic [31:0]  a_half;
   logic [31:0]  b_half;
   logic [63:0]  pp;
   logic [123:0] pp_sh;
   logic [62:0]  rem_sh;
   logic [123:0] shifted;
   logic [63:0]  mag_res;

   // State register and datapath registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         au_state_ff <= brf_pkg::AU_IDLE;
         done_ff     <= 1'b0;
      end else begin
         au_state_ff <= au_state_in;
         done_ff     <= done_in;
      end
      op_ff     <= op_in;
      neg_ff    <= neg_in;
      sat_ff    <= sat_in;
      a_ff      <= a_in;
      b_ff      <= b_in;
      acc_ff    <= acc_in;
      step_ff   <= step_in;
      rem_ff    <= rem_in;
      num_ff    <= num_in;
      quo_ff    <= quo_in;
      result_ff <= result_in;
   end

   // Sequencing of one multiply (four partial products) or one division (a bit a cycle).
   always_comb begin
      au_state_in = au_state_ff;
      op_in       = op_ff;
      neg_in      = neg_ff;
      sat_in      = sat_ff;
      a_in        = a_ff;
      b_in        = b_ff;
      acc_in      = acc_ff;
      step_in     = step_ff;
      rem_in      = rem_ff;
      num_in      = num_ff;
      quo_in      = quo_ff;
      result_in   = result_ff;
      done_in     = 1'b0;

      x_mag  = brf_pkg::mag_w(req_i.x);
      y_mag  = brf_pkg::mag_w(req_i.y);
      a_half = step_ff[0] ? {2'b00, a_ff[61:32]} : a_ff[31:0];
      b_half = step_ff[1] ? {2'b00, b_ff[61:32]} : b_ff[31:0];
      pp     = 64'(a_half) * 64'(b_half);
      case (step_ff[1:0])
         2'd0:    pp_sh = 124'(pp);
         2'd1:    pp_sh = 124'(pp) << 32;
         2'd2:    pp_sh = 124'(pp) << 32;
         default: pp_sh = 124'(pp) << 64;
      endcase
      rem_sh  = {rem_ff, num_ff[61]};
      shifted = (op_ff == brf_pkg::OP_MUL30) ? (acc_ff >> brf_pkg::RATIO_FRAC)
                                             : (acc_ff >> brf_pkg::EPS2_SHIFT);
      if (op_ff == brf_pkg::OP_DIV) begin
         mag_res = sat_ff ? 64'(brf_pkg::SAT_LIM) : {2'b00, quo_ff};
      end else if (|shifted[123:62]) begin
         mag_res = 64'(brf_pkg::SAT_LIM);
      end else begin
         mag_res = {2'b00, shifted[61:0]};
      end

      case (au_state_ff)
         brf_pkg::AU_IDLE: begin
            if (req_i.start) begin
               op_in   = req_i.op;
               neg_in  = req_i.x[63] ^ req_i.y[63];
               a_in    = x_mag[61:0];
               b_in    = y_mag[61:0];
               step_in = 6'd0;
               acc_in  = 124'd0;
               quo_in  = 62'd0;
               sat_in  = 1'b0;
               if (req_i.op == brf_pkg::OP_DIV) begin
                  // A zero divisor yields zero; a quotient of 2^32 or more saturates.
                  if (y_mag == 64'd0) begin
                     neg_in      = 1'b0;
                     au_state_in = brf_pkg::AU_FIN;
                  end else if ({34'd0, x_mag[61:32]} >= y_mag) begin
                     sat_in      = 1'b1;
                     au_state_in = brf_pkg::AU_FIN;
                  end else begin
                     rem_in      = {32'd0, x_mag[61:32]};
                     num_in      = {x_mag[31:0], 30'd0};
                     au_state_in = brf_pkg::AU_DIV;
                  end
               end else begin
                  au_state_in = brf_pkg::AU_MUL;
               end
            end
         end
         brf_pkg::AU_MUL: begin
            acc_in  = acc_ff + pp_sh;
            step_in = step_ff + 6'd1;
            if (step_ff[1:0] == 2'd3) begin
               au_state_in = brf_pkg::AU_FIN;
            end
         end
         brf_pkg::AU_DIV: begin
            if (rem_sh >= {1'b0, b_ff}) begin
               rem_in = 62'(rem_sh - {1'b0, b_ff});
               quo_in = {quo_ff[60:0], 1'b1};
            end else begin
               rem_in = rem_sh[61:0];
               quo_in = {quo_ff[60:0], 1'b0};
            end
            num_in  = {num_ff[60:0], 1'b0};
            step_in = step_ff + 6'd1;
            if (step_ff == 6'(brf_pkg::RATIO_BITS - 1)) begin
               au_state_in = brf_pkg::AU_FIN;
            end
         end
         brf_pkg::AU_FIN: begin
            result_in   = neg_ff ? -brf_pkg::wide_type'(mag_res)
                                 : brf_pkg::wide_type'(mag_res);
            done_in     = 1'b1;
            au_state_in = brf_pkg::AU_IDLE;
         end
         default: begin
            au_state_in = brf_pkg::AU_IDLE;
         end
      endcase
   end

   assign rsp_o.done   = done_ff;
   assign rsp_o.result = result_ff;

endmodule

// ===== test/tb_brent_root_finder.sv =====
// Self-checking testbench for the Brent root finder on the bracket [0,1].
// Depends on brf_pkg, brf_req_if, brf_rsp_if and brent_root_finder.
// Each search is driven with a synthetic function value, and every result is checked.
module tb_brent_root_finder;
   timeunit 1ns;
   timeprecision 1ps;
   import brf_pkg::*;

   localparam longint SAT_MAX  = 64'sh3FFF_FFFF_FFFF_FFFF;
   localparam longint Q30_ONE  = 64'sd1 <<< 30;
   localparam longint EPS2_MUL = 64'sd16888499;
   localparam longint PT_MAX   = 64'sd2147483647;
   localparam longint PT_MIN   = -64'sd2147483648;
   localparam logic [CSR_ADDR_WIDTH-1:0] ADDR_TOL   = {REG_TOLERANCE, 2'b00};
   localparam logic [CSR_ADDR_WIDTH-1:0] ADDR_MAXIT = {REG_MAX_ITER, 2'b00};

   typedef struct {
      point_type  point;
      logic       done_res;
      status_type status;
   } root_result_type;

   logic clock;
   logic reset;
   logic csr_psel, csr_penable, csr_pwrite, csr_pready;
   logic [CSR_ADDR_WIDTH-1:0] csr_paddr;
   logic [31:0] csr_pwdata, csr_prdata;

   brf_req_if req_ch ();
   brf_rsp_if rsp_ch ();

   brent_root_finder u_dut (
      .clock(clock), .reset(reset), .req_ch(req_ch.sink), .rsp_ch(rsp_ch.source),
      .csr_psel(csr_psel), .csr_penable(csr_penable), .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr), .csr_pwdata(csr_pwdata), .csr_prdata(csr_prdata),
      .csr_pready(csr_pready)
   );

   // Predicted state of the finder.
   longint unsigned tol_cfg;
   longint unsigned maxit_cfg;
   longint pt_b, pt_a, pt_c, fv_b, fv_a, fv_c, step_d, step_e;
   int unsigned iter_cnt;
   phase_type search_phase;

   root_result_type pending_results[$];
   int errors;
   int burst_left;
   int items_sent;
   logic last_done;
   point_type last_point;

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // Saturating arithmetic in the block's wide format.
   function automatic longint clamp_wide(longint x);
      if (x > SAT_MAX) return SAT_MAX;
      if (x < -SAT_MAX) return -SAT_MAX;
      return x;
   endfunction

   function automatic longint add_sat(longint x, longint y);
      return clamp_wide(clamp_wide(x) + clamp_wide(y));
   endfunction

   function automatic longint sub_sat(longint x, longint y);
      return clamp_wide(clamp_wide(x) - clamp_wide(y));
   endfunction

   function automatic longint unsigned abs_u(longint x);
      return x < 0 ? 64'd0 - longint'(x) : x;
   endfunction

   function automatic longint apply_sign(longint unsigned m, logic neg);
      if (m > SAT_MAX) m = SAT_MAX;
      return neg ? -longint'(m) : longint'(m);
   endfunction

   function automatic longint mul_shift(longint x, longint y, int sh);
      logic [127:0] prod;
      longint unsigned r;
      prod = 128'(abs_u(clamp_wide(x))) * 128'(abs_u(clamp_wide(y)));
      if ((prod >> (64 + sh - 2)) != 0) r = SAT_MAX;
      else r = 64'(prod >> sh);
      return apply_sign(r, (x < 0) != (y < 0));
   endfunction

   function automatic longint div_q30(longint n, longint d);
      longint unsigned nm, dm;
      logic [127:0] q;
      nm = abs_u(n);
      dm = abs_u(d);
      if (dm == 0) return 0;
      if (nm / dm >= (64'd1 << 32)) return apply_sign(SAT_MAX, (n < 0) != (d < 0));
      q = (128'(nm) << 30) / 128'(dm);
      return apply_sign(64'(q), (n < 0) != (d < 0));
   endfunction

   function automatic longint clamp_pt(longint x);
      if (x > PT_MAX) return PT_MAX;
      if (x < PT_MIN) return PT_MIN;
      return x;
   endfunction

   function automatic logic both_same_sign(longint x, longint y);
      return (x > 0 && y > 0) || (x < 0 && y < 0);
   endfunction

   // One Brent iteration on the predicted state.
   function automatic status_type brent_iterate(output longint pt);
      longint a, b, c, fa, fb, fc, d, e, tol1, xm, s, p, q, lim, m1, m2, qq, r, t1, t2, tmp;
      status_type st;
      a = pt_a; b = pt_b; c = pt_c; fa = fv_a; fb = fv_b; fc = fv_c; d = step_d; e = step_e;
      if (both_same_sign(fb, fc)) begin
         c = a; fc = fa; d = clamp_pt(sub_sat(b, a)); e = d;
      end
      if (abs_u(fc) < abs_u(fb)) begin
         a = b; b = c; c = a;
         tmp = fb; fa = fb; fb = fc; fc = tmp;
      end
      tol1 = add_sat(mul_shift(longint'(abs_u(b)), EPS2_MUL, 48), longint'(tol_cfg >> 1));
      xm = sub_sat(c, b) / 2;
      if (abs_u(xm) <= longint'(tol1) || fb == 0) begin
         st = STATUS_CONVERGED;
      end else begin
         if (abs_u(e) >= longint'(tol1) && abs_u(fa) > abs_u(fb)) begin
            s = div_q30(fb, fa);
            if (a == c) begin
               p = mul_shift(add_sat(xm, xm), s, 30);
               q = sub_sat(Q30_ONE, s);
            end else begin
               qq = div_q30(fa, fc);
               r = div_q30(fb, fc);
               t1 = mul_shift(mul_shift(add_sat(xm, xm), qq, 30), sub_sat(qq, r), 30);
               t2 = mul_shift(sub_sat(b, a), sub_sat(r, Q30_ONE), 30);
               p = mul_shift(s, sub_sat(t1, t2), 30);
               q = mul_shift(mul_shift(sub_sat(qq, Q30_ONE), sub_sat(r, Q30_ONE), 30),
                             sub_sat(s, Q30_ONE), 30);
            end
            if (p > 0) q = -q;
            p = longint'(abs_u(p));
            m1 = sub_sat(mul_shift(add_sat(add_sat(xm, xm), xm), q, 30),
                         longint'(abs_u(mul_shift(tol1, q, 30))));
            m2 = longint'(abs_u(mul_shift(e, q, 30)));
            lim = m1 < m2 ? m1 : m2;
            if (add_sat(p, p) < lim) begin
               e = d; d = clamp_pt(div_q30(p, q));
            end else begin
               d = clamp_pt(xm); e = d;
            end
         end else begin
            d = clamp_pt(xm); e = d;
         end
         a = b;
         fa = fb;
         if (abs_u(d) > longint'(tol1)) b = clamp_pt(add_sat(b, d));
         else if (xm < 0) b = clamp_pt(sub_sat(b, tol1));
         else b = clamp_pt(add_sat(b, tol1));
         iter_cnt++;
         st = (iter_cnt >= maxit_cfg) ? STATUS_LIMIT : STATUS_BUSY;
      end
      pt_a = a; pt_b = b; pt_c = c; fv_a = fa; fv_b = fb; fv_c = fc;
      step_d = d; step_e = e;
      pt = b;
      return st;
   endfunction

   // Works out the result of one accepted item.
   function automatic root_result_type predict_step(logic mode, value_type fval);
      root_result_type res;
      longint fv, pt;
      status_type st;
      fv = fval;
      pt = 0;
      st = STATUS_UNBRACKETED;
      if (mode == 1'b0) begin
         pt_a = 0; fv_a = fv; pt_b = Q30_ONE; iter_cnt = 0;
         search_phase = PH_FIRST;
         pt = pt_b; st = STATUS_BUSY;
      end else if (search_phase == PH_FIRST) begin
         fv_b = fv;
         if (both_same_sign(fv_a, fv)) begin
            search_phase = PH_IDLE;
         end else begin
            pt_c = 0; fv_c = fv; step_d = 0; step_e = 0; iter_cnt = 0;
            if (maxit_cfg == 0) begin
               pt = pt_b; st = STATUS_LIMIT;
            end else begin
               st = brent_iterate(pt);
            end
            search_phase = (st == STATUS_BUSY) ? PH_REFINE : PH_IDLE;
         end
      end else if (search_phase == PH_REFINE) begin
         fv_b = fv;
         st = brent_iterate(pt);
         search_phase = (st == STATUS_BUSY) ? PH_REFINE : PH_IDLE;
      end
      res.point = point_type'(pt);
      res.done_res = (st != STATUS_BUSY);
      res.status = st;
      return res;
   endfunction

   // Sends one item in bursts with random gaps; called at a rising edge.
   task automatic send_item(logic mode, value_type fval);
      root_result_type res;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 12);
         if ($urandom_range(0, 2) != 0) begin
            req_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge clock);
         end
      end
      burst_left--;
      items_sent++;
      req_ch.valid <= 1'b1;
      req_ch.mode <= mode;
      req_ch.fvalue <= fval;
      res = predict_step(mode, fval);
      pending_results.push_back(res);
      last_done = res.done_res;
      last_point = res.point;
      forever begin
         @(posedge clock);
         if (req_ch.ready) break;
      end
   endtask

   // Lowers valid and waits until every predicted result has arrived.
   task automatic drain_results();
      req_ch.valid <= 1'b0;
      burst_left = 0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   // Register write with setup and access cycles; only while idle.
   task automatic csr_write(logic [CSR_ADDR_WIDTH-1:0] addr, logic [31:0] data);
      drain_results();
      csr_psel <= 1'b1; csr_penable <= 1'b0; csr_pwrite <= 1'b1;
      csr_paddr <= addr; csr_pwdata <= data;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel <= 1'b0; csr_penable <= 1'b0; csr_pwrite <= 1'b0;
      if (addr == ADDR_TOL) tol_cfg = data & 32'h7FFF_FFFF;
      else maxit_cfg = data & 32'h3FF;
      @(posedge clock);
   endtask

   // Synthetic function with a root in the bracket: linear or cubic about the root.
   function automatic value_type eval_func(point_type t, longint root, longint gain,
                                           logic cubic, logic negate);
      longint dx, v;
      dx = longint'(t) - root;
      if (cubic) dx = (((dx * dx) >>> 30) * dx) >>> 30;
      v = ((dx >>> 6) * gain) >>> 8;
      if (negate) v = -v;
      if (v > 64'sd2147483647) v = 64'sd2147483647;
      if (v < -64'sd2147483648) v = -64'sd2147483648;
      return value_type'(v);
   endfunction

   // One search: start, then answer each requested point until done or cut short.
   task automatic run_search(int max_steps);
      longint root, gain;
      logic cubic, negate;
      int steps;
      root = $urandom_range(0, 32'h4000_0000);
      gain = $urandom_range(1, 4096);
      cubic = $urandom_range(0, 3) == 0;
      negate = 1'($urandom_range(0, 1));
      send_item(1'b0, eval_func(0, root, gain, cubic, negate));
      steps = 0;
      while (!last_done && steps < max_steps) begin
         send_item(1'b1, eval_func(last_point, root, gain, cubic, negate));
         steps++;
      end
   endtask

   task automatic test_directed();
      send_item(1'b1, 32'sd5);                       // value with no search running
      send_item(1'b0, 32'sd1 <<< 24);                // unbracketed pair
      send_item(1'b1, 32'sd3 <<< 24);
      send_item(1'b0, -32'sd2147483648);             // opposite extremes, then refine
      send_item(1'b1, 32'sd2147483647);
      send_item(1'b1, 32'sd0);                       // exact zero converges
      send_item(1'b0, 32'sd0);                       // f(0) zero
      send_item(1'b1, 32'sd7);
      send_item(1'b0, -32'sd1000);                   // new search after a converged one
      send_item(1'b1, 32'sd3000);
      send_item(1'b0, 32'sd2147483647);
      send_item(1'b1, -32'sd1);
      send_item(1'b1, 32'sd2147483647);
      send_item(1'b1, -32'sd2147483648);
      send_item(1'b0, -32'sd2147483648);             // both negative: unbracketed
      send_item(1'b1, -32'sd2147483648);
      run_search(40);
   endtask

   task automatic test_config_extremes();
      csr_write(ADDR_MAXIT, 32'd0);                  // zero limit returns at once
      send_item(1'b0, -32'sd500);
      send_item(1'b1, 32'sd500);
      csr_write(ADDR_MAXIT, 32'd1);
      run_search(5);
      csr_write(ADDR_TOL, 32'h7FFF_FFFF);            // huge tolerance
      csr_write(ADDR_MAXIT, 32'd1023);
      run_search(10);
      csr_write(ADDR_TOL, 32'd0);                    // zero tolerance
      csr_write(ADDR_MAXIT, 32'd30);
      run_search(40);
      run_search(40);
   endtask

   task automatic test_random(int items);
      int sent_before;
      int first_sent;
      first_sent = items_sent;
      while (items_sent - first_sent < items) begin
         sent_before = $urandom_range(0, 9);
         if (sent_before == 0) begin
            send_item(1'($urandom_range(0, 1)), value_type'($urandom));
         end else begin
            run_search($urandom_range(3, 30));
         end
         if ($urandom_range(0, 40) == 0) begin
            case ($urandom_range(0, 3))
               0: csr_write(ADDR_TOL, $urandom_range(0, 32'h7FFF_FFFF));
               1: csr_write(ADDR_TOL, $urandom_range(0, 20000));
               2: csr_write(ADDR_MAXIT, $urandom_range(0, 1023));
               default: csr_write(ADDR_MAXIT, $urandom_range(1, 25));
            endcase
         end
      end
      drain_results();
      csr_write(ADDR_TOL, 32'd10737);
      csr_write(ADDR_MAXIT, 32'd100);
   endtask

   // Receiver stall pattern: runs of stalls and runs without any.
   int stall_run;
   logic stall_on;
   always @(posedge clock) begin
      if (stall_run == 0) begin
         stall_run <= $urandom_range(1, 40);
         stall_on <= ($urandom_range(0, 2) == 0);
      end else begin
         stall_run <= stall_run - 1;
      end
      rsp_ch.ready <= reset ? 1'b0 : (stall_on ? ($urandom_range(0, 3) == 0) : 1'b1);
   end

   // Result checker against the oldest prediction.
   always @(posedge clock) begin
      root_result_type exp_res;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (pending_results.size() == 0) begin
            $error("unexpected result item: point %0d", rsp_ch.point);
            errors++;
         end else begin
            exp_res = pending_results.pop_front();
            if (rsp_ch.point !== exp_res.point) begin
               $error("point: expected %0d, actual %0d", exp_res.point, rsp_ch.point);
               errors++;
            end
            if (rsp_ch.done_res !== exp_res.done_res) begin
               $error("done_res: expected %0d, actual %0d", exp_res.done_res, rsp_ch.done_res);
               errors++;
            end
            if (rsp_ch.status !== exp_res.status) begin
               $error("status: expected %0d, actual %0d", exp_res.status, rsp_ch.status);
               errors++;
            end
         end
      end
   end

   // Stimulus sequence.
   initial begin
      errors = 0; burst_left = 0; stall_run = 0; stall_on = 1'b0; items_sent = 0;
      tol_cfg = 10737; maxit_cfg = 100;
      pt_a = 0; pt_b = 0; pt_c = 0; fv_a = 0; fv_b = 0; fv_c = 0; step_d = 0; step_e = 0;
      iter_cnt = 0; search_phase = PH_IDLE;
      reset = 1'b1;
      req_ch.valid = 1'b0; req_ch.mode = 1'b0; req_ch.fvalue = '0;
      rsp_ch.ready = 1'b0;
      csr_psel = 1'b0; csr_penable = 1'b0; csr_pwrite = 1'b0;
      csr_paddr = '0; csr_pwdata = '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_config_extremes();
      test_random(1050);
      drain_results();
      repeat (400) @(posedge clock);
      if (errors == 0) $display("Simulation PASSED");
      else $display("Simulation FAILED");
      $finish;
   end

   // Watchdog.
   initial begin
      #20000000;
      $display("Simulation FAILED");
      $finish;
   end

endmodule

// ===== brent_root_finder.f =====
+incdir+rtl
rtl/brf_pkg.sv
rtl/brf_req_if.sv
rtl/brf_rsp_if.sv
rtl/brf_arith_unit.sv
rtl/brent_root_finder.sv
test/tb_brent_root_finder.sv
